[src/lslf_pkg.sv]
// Shared constants, widths and types of the least-squares line fit.
package lslf_pkg;

  localparam int MAX_POINTS    = 4096;
  localparam int FRACTION_BITS = 16;

  localparam int X_W    = 16;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SX_W   = X_W + CNT_W;
  localparam int SQ_W   = 2 * X_W + CNT_W;
  localparam int OUT_W  = 48;
  localparam int STAT_W = 2;
  localparam int USED_W = 13;

  // Sequential multiplier: magnitude operands, one bit of b per cycle.
  localparam int MA_W      = SQ_W;
  localparam int MB_W      = SX_W;
  localparam int PR_W      = MA_W + MB_W;
  localparam int SP_W      = PR_W + 1;
  localparam int DF_W      = PR_W + 2;
  localparam int MUL_CNT_W = $clog2(MB_W + 1);

  // Restoring divider: one quotient bit per cycle.
  localparam int DEN_W     = DF_W;
  localparam int DVD_W     = DF_W + FRACTION_BITS;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  localparam logic [OUT_W-1:0] SAT_POS_MAG = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [STAT_W-1:0] {
    FIT_OK         = 2'd0,
    FIT_DEGENERATE = 2'd1,
    FIT_DROPPED    = 2'd2
  } fit_status_t;

  // Totals of one finished set of pairs.
  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SX_W-1:0]  sx;
    logic signed [SX_W-1:0]  sy;
    logic signed [SQ_W-1:0]  sxx;
    logic signed [SQ_W-1:0]  sxy;
    logic                    dropped;
  } sums_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[src/least_squares_line_fit.sv]
// Least-squares straight-line fit over a stream of signed (x, y) sample words.
// Pairs are taken at one word per cycle and summed; the word marked last closes
// the set and one result word follows with slope and intercept in signed fixed
// point with 16 fraction bits, truncated toward zero and saturated to 48 bits.
// The fit of a set runs on a shared shift-and-add multiplier (one bit per
// cycle, six products) and a restoring divider (one quotient bit per cycle,
// two divisions, skipped when the denominator is zero). Input keeps flowing
// meanwhile; a two-entry queue holds finished sets, and the input is stalled
// only while both entries are occupied. Pairs past 4096 in one set are dropped
// and reported in the status field.
module least_squares_line_fit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lslf_pkg::X_W-1:0]     in_x_value,
  input  logic signed [lslf_pkg::X_W-1:0]     in_y_value,
  input  logic                                in_last_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lslf_pkg::OUT_W-1:0]   out_slope,
  output logic signed [lslf_pkg::OUT_W-1:0]   out_intercept,
  output logic [lslf_pkg::STAT_W-1:0]         out_fit_status,
  output logic [lslf_pkg::USED_W-1:0]         out_points_used
);
  import lslf_pkg::*;

  q_stat_t q_stat;
  sums_t   push_data;
  sums_t   q_head;
  logic    push;
  logic    q_pop;

  lslf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_x_value    (in_x_value),
    .in_y_value    (in_y_value),
    .in_last_point (in_last_point),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  lslf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .head      (q_head),
    .q_stat    (q_stat)
  );

  lslf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slope       (out_slope),
    .out_intercept   (out_intercept),
    .out_fit_status  (out_fit_status),
    .out_points_used (out_points_used)
  );

endmodule

[src/lslf_front.sv]
// Front end: takes sample pairs and keeps the running count and sums.
module lslf_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [lslf_pkg::X_W-1:0]   in_x_value,
  input  logic signed [lslf_pkg::X_W-1:0]   in_y_value,
  input  logic                              in_last_point,
  input  lslf_pkg::q_stat_t                 q_stat,
  output logic                              push,
  output lslf_pkg::sums_t                   push_data
);
  import lslf_pkg::*;

  sums_t                    acc_r;
  sums_t                    acc_nxt;
  logic signed [2*X_W-1:0]  xx;
  logic signed [2*X_W-1:0]  xy;
  logic                     accept;

  assign xx       = in_x_value * in_x_value;
  assign xy       = in_x_value * in_y_value;
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    acc_nxt = acc_r;
    if (acc_r.count < CNT_W'(MAX_POINTS)) begin
      acc_nxt.count = acc_r.count + CNT_W'(1);
      acc_nxt.sx    = acc_r.sx + SX_W'(in_x_value);
      acc_nxt.sy    = acc_r.sy + SX_W'(in_y_value);
      acc_nxt.sxx   = acc_r.sxx + SQ_W'(xx);
      acc_nxt.sxy   = acc_r.sxy + SQ_W'(xy);
    end else begin
      acc_nxt.dropped = 1'b1;
    end
  end

  // The closing pair goes out with its own contribution already added.
  assign push      = accept && in_last_point;
  assign push_data = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (accept) begin
      acc_r <= in_last_point ? sums_t'('0) : acc_nxt;
    end
  end

endmodule

[src/lslf_fifo.sv]
// Short queue of finished sets between the front end and the fit engine.
module lslf_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lslf_pkg::sums_t    push_data,
  input  logic               pop,
  output lslf_pkg::sums_t    head,
  output lslf_pkg::q_stat_t  q_stat
);
  import lslf_pkg::*;

  sums_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_CNT_W-1:0]  cnt_r;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
  endfunction

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/lslf_mul.sv]
// Shift-and-add multiplier on magnitudes, one multiplier bit per cycle.
module lslf_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [lslf_pkg::MA_W-1:0]          a_mag,
  input  logic [lslf_pkg::MB_W-1:0]          b_mag,
  input  logic                               neg,
  output logic                               done,
  output logic signed [lslf_pkg::SP_W-1:0]   product
);
  import lslf_pkg::*;

  logic                   busy_r;
  logic                   fix_r;
  logic                   done_r;
  logic [MUL_CNT_W-1:0]   cnt_r;
  logic [PR_W-1:0]        acc_r;
  logic [PR_W-1:0]        ash_r;
  logic [MB_W-1:0]        b_r;
  logic                   neg_r;
  logic signed [SP_W-1:0] prod_r;
  logic signed [SP_W-1:0] acc_s;

  assign acc_s   = $signed({1'b0, acc_r});
  assign done    = done_r;
  assign product = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + MUL_CNT_W'(1);
        if (cnt_r == MUL_CNT_W'(MB_W - 1)) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end else if (fix_r) begin
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      ash_r <= PR_W'(a_mag);
      b_r   <= b_mag;
      neg_r <= neg;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + ash_r;
      end
      ash_r <= ash_r << 1;
      b_r   <= b_r >> 1;
    end else if (fix_r) begin
      prod_r <= neg_r ? -acc_s : acc_s;
    end
  end

endmodule

[src/lslf_div.sv]
// Restoring divider with truncation toward zero and 48-bit saturation.
module lslf_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [lslf_pkg::DVD_W-1:0]          dividend,
  input  logic [lslf_pkg::DEN_W-1:0]          divisor,
  input  logic                                neg,
  output logic                                done,
  output logic signed [lslf_pkg::OUT_W-1:0]   quotient
);
  import lslf_pkg::*;

  logic                    busy_r;
  logic                    fix_r;
  logic                    done_r;
  logic [DIV_CNT_W-1:0]    cnt_r;
  logic [DEN_W-1:0]        rem_r;
  logic [DVD_W-1:0]        q_r;
  logic [DEN_W-1:0]        den_r;
  logic                    neg_r;
  logic signed [OUT_W-1:0] quo_r;
  logic [DEN_W:0]          trial;
  logic [DEN_W:0]          trial_sub;
  logic                    ge;
  logic [OUT_W-1:0]        lim;
  logic [OUT_W-1:0]        mag;

  // The remainder stays below the divisor, so the trial fits one extra bit.
  assign trial     = {rem_r, q_r[DVD_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign ge        = (trial >= {1'b0, den_r});

  assign lim = neg_r ? SAT_NEG_MAG : SAT_POS_MAG;
  assign mag = (q_r > DVD_W'(lim)) ? lim : q_r[OUT_W-1:0];

  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end else if (fix_r) begin
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      den_r <= divisor;
      neg_r <= neg;
    end else if (busy_r) begin
      rem_r <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      q_r   <= {q_r[DVD_W-2:0], ge};
    end else if (fix_r) begin
      quo_r <= neg_r ? $signed(-mag) : $signed(mag);
    end
  end

endmodule

[src/lslf_back.sv]
// Fit engine: forms the denominator and the two numerators and divides them.
module lslf_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lslf_pkg::q_stat_t                   q_stat,
  input  lslf_pkg::sums_t                     q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lslf_pkg::OUT_W-1:0]   out_slope,
  output logic signed [lslf_pkg::OUT_W-1:0]   out_intercept,
  output logic [lslf_pkg::STAT_W-1:0]         out_fit_status,
  output logic [lslf_pkg::USED_W-1:0]         out_points_used
);
  import lslf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_GO,
    S_MUL_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  // Products in the order they are formed; each odd one closes a difference.
  typedef enum logic [2:0] {
    P_N_SXX,
    P_SX_SX,
    P_N_SXY,
    P_SX_SY,
    P_SXX_SY,
    P_SX_SXY
  } prod_t;

  state_t                  state_r;
  prod_t                   sel_r;
  logic                    div_icpt_r;
  sums_t                   s_r;
  logic signed [SP_W-1:0]  ph_r;
  logic signed [DF_W-1:0]  den_r;
  logic signed [DF_W-1:0]  ns_r;
  logic signed [DF_W-1:0]  ni_r;
  logic signed [OUT_W-1:0] slope_r;
  logic signed [OUT_W-1:0] icpt_r;
  fit_status_t             status_r;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_slope_r;
  logic signed [OUT_W-1:0] out_icpt_r;
  fit_status_t             out_status_r;
  logic [USED_W-1:0]       out_used_r;

  logic signed [SX_W-1:0]  n_s;
  logic signed [SQ_W-1:0]  a_s;
  logic signed [SX_W-1:0]  b_s;
  logic [MA_W-1:0]         a_mag;
  logic [MB_W-1:0]         b_mag;
  logic                    mul_start;
  logic                    mul_done;
  logic signed [SP_W-1:0]  mul_product;
  logic signed [DF_W-1:0]  diff;

  logic signed [DF_W-1:0]  num;
  logic [DF_W-1:0]         num_mag;
  logic                    den_zero;
  logic                    div_start;
  logic                    div_done;
  logic signed [OUT_W-1:0] div_quotient;

  assign n_s = $signed(SX_W'(s_r.count));

  always_comb begin
    a_s = '0;
    b_s = '0;
    unique case (sel_r)
      P_N_SXX: begin
        a_s = s_r.sxx;
        b_s = n_s;
      end
      P_SX_SX: begin
        a_s = SQ_W'(s_r.sx);
        b_s = s_r.sx;
      end
      P_N_SXY: begin
        a_s = s_r.sxy;
        b_s = n_s;
      end
      P_SX_SY: begin
        a_s = SQ_W'(s_r.sx);
        b_s = s_r.sy;
      end
      P_SXX_SY: begin
        a_s = s_r.sxx;
        b_s = s_r.sy;
      end
      P_SX_SXY: begin
        a_s = s_r.sxy;
        b_s = s_r.sx;
      end
      default: begin
        a_s = '0;
        b_s = '0;
      end
    endcase
  end

  assign a_mag     = a_s[SQ_W-1] ? MA_W'(-a_s) : MA_W'(a_s);
  assign b_mag     = b_s[SX_W-1] ? MB_W'(-b_s) : MB_W'(b_s);
  assign mul_start = (state_r == S_MUL_GO);
  assign diff      = DF_W'(ph_r) - DF_W'(mul_product);

  lslf_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a_mag   (a_mag),
    .b_mag   (b_mag),
    .neg     (a_s[SQ_W-1] ^ b_s[SX_W-1]),
    .done    (mul_done),
    .product (mul_product)
  );

  assign num       = div_icpt_r ? ni_r : ns_r;
  assign num_mag   = num[DF_W-1] ? DF_W'(-num) : DF_W'(num);
  assign den_zero  = (den_r == '0);
  assign div_start = (state_r == S_DIV_GO) && !den_zero;

  lslf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DVD_W'(num_mag) << FRACTION_BITS),
    .divisor  (DEN_W'($unsigned(den_r))),
    .neg      (num[DF_W-1]),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign q_pop = (state_r == S_IDLE) && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the valid flag is handled by the state itself.
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            s_r        <= q_head;
            sel_r      <= P_N_SXX;
            div_icpt_r <= 1'b0;
            state_r    <= S_MUL_GO;
          end
        end
        S_MUL_GO: begin
          state_r <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_done) begin
            unique case (sel_r)
              P_SX_SX:  den_r <= diff;
              P_SX_SY:  ns_r  <= diff;
              P_SX_SXY: ni_r  <= diff;
              default:  ph_r  <= mul_product;
            endcase
            if (sel_r == P_SX_SXY) begin
              state_r <= S_DIV_GO;
            end else begin
              sel_r   <= prod_t'(sel_r + 3'd1);
              state_r <= S_MUL_GO;
            end
          end
        end
        S_DIV_GO: begin
          // A zero denominator means all x were equal or only one pair came in.
          if (den_zero) begin
            slope_r  <= '0;
            icpt_r   <= '0;
            status_r <= FIT_DEGENERATE;
            state_r  <= S_DONE;
          end else begin
            status_r <= s_r.dropped ? FIT_DROPPED : FIT_OK;
            state_r  <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (!div_icpt_r) begin
              slope_r    <= div_quotient;
              div_icpt_r <= 1'b1;
              state_r    <= S_DIV_GO;
            end else begin
              icpt_r  <= div_quotient;
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_slope_r  <= slope_r;
            out_icpt_r   <= icpt_r;
            out_status_r <= status_r;
            out_used_r   <= USED_W'(s_r.count);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slope       = out_slope_r;
  assign out_intercept   = out_icpt_r;
  assign out_fit_status  = out_status_r;
  assign out_points_used = out_used_r;

endmodule

[src/lslf_checker.sv]
// Port-level checks of the line fit and the bind that attaches them.
module lslf_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic signed [lslf_pkg::X_W-1:0]     in_x_value,
  input logic signed [lslf_pkg::X_W-1:0]     in_y_value,
  input logic                                in_last_point,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [lslf_pkg::OUT_W-1:0]   out_slope,
  input logic signed [lslf_pkg::OUT_W-1:0]   out_intercept,
  input logic [lslf_pkg::STAT_W-1:0]         out_fit_status,
  input logic [lslf_pkg::USED_W-1:0]         out_points_used
);
  import lslf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slope) &&
      $stable(out_intercept) && $stable(out_fit_status) && $stable(out_points_used))
    else $error("result word changed while stalled");

  a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_points_used <= USED_W'(MAX_POINTS))
    else $error("more pairs used than the capacity allows");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fit_status == FIT_DEGENERATE |-> out_slope == '0 && out_intercept == '0)
    else $error("degenerate fit with nonzero slope or intercept");

  a_few_points: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_points_used < USED_W'(2) |-> out_fit_status == FIT_DEGENERATE)
    else $error("fewer than two pairs but fit not flagged degenerate");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fit_status == FIT_DROPPED |-> out_points_used == USED_W'(MAX_POINTS))
    else $error("dropped pairs reported below capacity");

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (.*);
